// ===== src/afs_pkg.sv =====
// Shared types and constants for the arming and failsafe supervisor.
`default_nettype none

package afs_pkg;

    // Event codes carried in the input mode field
    typedef enum logic [2:0] {
        EV_TICK    = 3'd0,
        EV_PACKET  = 3'd1,
        EV_IMU     = 3'd2,
        EV_BARO    = 3'd3,
        EV_BATTERY = 3'd4
    } t_event;

    // Flight modes
    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_FAILSAFE = 2'd2
    } t_flight_mode;

    // Packet keys
    typedef enum logic [1:0] {
        KEY_DISARM   = 2'd0,
        KEY_ARM      = 2'd1,
        KEY_FAILSAFE = 2'd2,
        KEY_UNKNOWN  = 2'd3
    } t_packet_key;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_RADIO_TIMEOUT = 2'd0,
        REG_IMU_TIMEOUT   = 2'd1,
        REG_BARO_TIMEOUT  = 2'd2,
        REG_ACK_INTERVAL  = 2'd3
    } t_reg_index;

    // Failsafe cause bit positions
    localparam int unsigned CAUSE_RADIO_BIT  = 0;
    localparam int unsigned CAUSE_IMU_BIT    = 1;
    localparam int unsigned CAUSE_BARO_BIT   = 2;
    localparam int unsigned CAUSE_REMOTE_BIT = 3;

    // Field and register widths
    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned PHASE_W  = 8;
    localparam int unsigned CAUSE_W  = 4;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    // Register reset values
    localparam logic [TIMER_W-1:0] RADIO_TIMEOUT_RST = 16'd100;
    localparam logic [TIMER_W-1:0] IMU_TIMEOUT_RST   = 16'd50;
    localparam logic [TIMER_W-1:0] BARO_TIMEOUT_RST  = 16'd1000;
    localparam logic [PHASE_W-1:0] ACK_INTERVAL_RST  = 8'd10;

    // One input item
    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] packet_key;
        logic       packet_size_ok;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [1:0]         flight_mode;
        logic [CAUSE_W-1:0] failsafe_causes;
        logic [1:0]         ack_key;
        logic               ack_with_payload;
    } t_out_item;

endpackage

`default_nettype wire

// ===== src/arming_failsafe_supervisor_top.sv =====
// Arming and failsafe supervisor: event-driven mode, cause and timeout tracking.
`default_nettype none

// Each accepted event (ms tick, radio packet, IMU ready, baro ready, battery
// empty) yields exactly one result with the flight mode after the event, the
// latched failsafe causes and, for packets, the acknowledgement key and
// payload flag. An item is held in the input register and is then
// evaluated against the supervisor state into the result register, so one
// event can be taken every cycle while the result side keeps up. Failsafe
// latches until reset. Timeout and acknowledgement registers sit on the APB
// port at byte addresses 0x0, 0x4, 0x8 and 0xC and should be written only
// while no event is in flight.
module arming_failsafe_supervisor_top
    import afs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // event input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_data,
    // result output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_data,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // Configuration registers
    logic [TIMER_W-1:0] r_radio_timeout;
    logic [TIMER_W-1:0] r_imu_timeout;
    logic [TIMER_W-1:0] r_baro_timeout;
    logic [PHASE_W-1:0] r_ack_interval;

    // Supervisor state
    t_flight_mode       r_mode,        n_mode;
    logic [CAUSE_W-1:0] r_causes,      n_causes;
    logic               r_disarm_seen, n_disarm_seen;
    logic               r_pkt_seen,    n_pkt_seen;
    logic [PHASE_W-1:0] r_phase,       n_phase;
    logic [TIMER_W-1:0] r_radio_el,    n_radio_el;
    logic [TIMER_W-1:0] r_imu_el,      n_imu_el;
    logic [TIMER_W-1:0] r_baro_el,     n_baro_el;

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic                 cfg_wr;
    logic                 advance;
    logic [PHASE_W:0]     phase_inc;
    logic [1:0]           reg_idx;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_RADIO_TIMEOUT: prdata = {{(PDATA_W-TIMER_W){1'b0}}, r_radio_timeout};
            REG_IMU_TIMEOUT:   prdata = {{(PDATA_W-TIMER_W){1'b0}}, r_imu_timeout};
            REG_BARO_TIMEOUT:  prdata = {{(PDATA_W-TIMER_W){1'b0}}, r_baro_timeout};
            REG_ACK_INTERVAL:  prdata = {{(PDATA_W-PHASE_W){1'b0}}, r_ack_interval};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radio_timeout <= RADIO_TIMEOUT_RST;
            r_imu_timeout   <= IMU_TIMEOUT_RST;
            r_baro_timeout  <= BARO_TIMEOUT_RST;
            r_ack_interval  <= ACK_INTERVAL_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RADIO_TIMEOUT: r_radio_timeout <= pwdata[TIMER_W-1:0];
                REG_IMU_TIMEOUT:   r_imu_timeout   <= pwdata[TIMER_W-1:0];
                REG_BARO_TIMEOUT:  r_baro_timeout  <= pwdata[TIMER_W-1:0];
                REG_ACK_INTERVAL:  r_ack_interval  <= pwdata[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: stage advances when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Event evaluation
    assign phase_inc = {1'b0, r_phase} + 1'b1;

    always_comb begin
        n_mode        = r_mode;
        n_causes      = r_causes;
        n_disarm_seen = r_disarm_seen;
        n_pkt_seen    = r_pkt_seen;
        n_phase       = r_phase;
        n_radio_el    = r_radio_el;
        n_imu_el      = r_imu_el;
        n_baro_el     = r_baro_el;
        n_out         = '0;

        if (r_mode == MODE_FAILSAFE) begin
            // latched: state holds, and a packet only gets the ack key set to the mode
            if (r_in.mode == EV_PACKET) begin
                n_out.ack_key = MODE_FAILSAFE;
            end
        end else begin
            case (r_in.mode)
                EV_TICK: begin
                    n_radio_el = sat_inc(r_radio_el);
                    n_imu_el   = sat_inc(r_imu_el);
                    n_baro_el  = sat_inc(r_baro_el);
                end
                EV_PACKET: begin
                    n_out.ack_key = r_mode;
                    n_radio_el    = '0;
                    n_pkt_seen    = 1'b1;
                    if (phase_inc >= {1'b0, r_ack_interval}) begin
                        n_phase                = '0;
                        n_out.ack_with_payload = 1'b1;
                    end else begin
                        n_phase = phase_inc[PHASE_W-1:0];
                    end
                    if (r_in.packet_size_ok) begin
                        case (r_in.packet_key)
                            KEY_DISARM: begin
                                n_disarm_seen = 1'b1;
                                n_mode        = MODE_DISARMED;
                            end
                            KEY_ARM: begin
                                if (r_disarm_seen) begin
                                    n_mode = MODE_ARMED;
                                end
                            end
                            KEY_FAILSAFE: begin
                                n_mode                     = MODE_FAILSAFE;
                                n_causes[CAUSE_REMOTE_BIT] = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                EV_IMU:     n_imu_el  = '0;
                EV_BARO:    n_baro_el = '0;
                EV_BATTERY: n_mode    = MODE_FAILSAFE;
                default: ;
            endcase

            // timeout checks on the updated counters
            if (n_pkt_seen && (n_radio_el > r_radio_timeout)) begin
                n_mode                    = MODE_FAILSAFE;
                n_causes[CAUSE_RADIO_BIT] = 1'b1;
            end
            if (n_imu_el > r_imu_timeout) begin
                n_mode                  = MODE_FAILSAFE;
                n_causes[CAUSE_IMU_BIT] = 1'b1;
            end
            if (n_baro_el > r_baro_timeout) begin
                n_mode                   = MODE_FAILSAFE;
                n_causes[CAUSE_BARO_BIT] = 1'b1;
            end
        end

        n_out.flight_mode     = n_mode;
        n_out.failsafe_causes = n_causes;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_mode        <= MODE_DISARMED;
            r_causes      <= '0;
            r_disarm_seen <= 1'b0;
            r_pkt_seen    <= 1'b0;
            r_phase       <= '0;
            r_radio_el    <= '0;
            r_imu_el      <= '0;
            r_baro_el     <= '0;
        end else begin
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_mode        <= n_mode;
                r_causes      <= n_causes;
                r_disarm_seen <= n_disarm_seen;
                r_pkt_seen    <= n_pkt_seen;
                r_phase       <= n_phase;
                r_radio_el    <= n_radio_el;
                r_imu_el      <= n_imu_el;
                r_baro_el     <= n_baro_el;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
